// ===== src/assert_macros.svh =====
// Assertion macros shared by the RTL of the padded text formatter.
// Depends on nothing; files that check their own logic include it.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// The condition must hold at every clock edge outside reset.
`define ASSERT_HOLDS(label, clk, rst, cond, msg) \
   label: assert property (@(posedge clk) disable iff (rst) (cond)) else $error(msg);

// The consequent must hold in the same cycle as the antecedent.
`define ASSERT_IMPL(label, clk, rst, ante, cons, msg) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) else $error(msg);

// The consequent must hold in the cycle after the antecedent.
`define ASSERT_NEXT(label, clk, rst, ante, cons, msg) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) else $error(msg);

`endif

// ===== src/itpt_pkg.sv =====
// Package of the padded text formatter: field widths, character codes,
// digit base and sequencer types, and small helper functions. No dependencies.
`default_nettype none

package itpt_pkg;

   localparam int VALUE_W        = 64;
   localparam int BASE_W         = 3;
   localparam int FIELD_WIDTH_W  = 7;
   localparam int CHAR_W         = 32;
   localparam int COUNT_W        = 3;
   localparam int GROUP_CHARS    = 4;
   // Text positions: the field never exceeds 127 characters plus one group.
   localparam int POS_W          = 8;

   localparam int WIDTH_CAP_DEF  = 64;
   localparam int VALUE_BITS_DEF = 64;

   localparam logic [CHAR_W-1:0] CHAR_SPACE = 32'h20;
   localparam logic [CHAR_W-1:0] CHAR_ZERO  = 32'h30;
   localparam logic [CHAR_W-1:0] CHAR_MINUS = 32'h2D;
   localparam logic [CHAR_W-1:0] CHAR_PLUS  = 32'h2B;
   localparam logic [CHAR_W-1:0] CHAR_A_LO  = 32'h61;
   localparam logic [CHAR_W-1:0] CHAR_A_UP  = 32'h41;

   typedef enum logic [BASE_W-1:0] {
      BASE_DEC    = 3'd0,
      BASE_HEX_LO = 3'd1,
      BASE_HEX_UP = 3'd2,
      BASE_OCT    = 3'd3,
      BASE_BIN    = 3'd4
   } base_type;

   typedef enum logic [2:0] {
      ST_IDLE,
      ST_CONV,
      ST_SCAN,
      ST_LAYOUT,
      ST_EMIT
   } state_type;

   // Layout of one request's text, shared by the sequencer and the lanes.
   typedef struct packed {
      logic [POS_W-1:0] lead_sp;
      logic [POS_W-1:0] dstart;
      logic [POS_W-1:0] dend;
      logic [POS_W-1:0] total;
      logic             has_sign;
      logic             sign_neg;
      logic             char_mode;
      base_type         base;
   } lay_type;

   typedef struct packed {
      logic load;
      logic step;
   } conv_cmd_type;

   // Decimal digits needed for the largest value of the given bit count.
   function automatic int dec_digits(input int bits);
      return (bits * 30103) / 100000 + 1;
   endfunction

   // Codes without a meaning format in decimal.
   function automatic base_type decode_base(input logic [BASE_W-1:0] raw);
      base_type b;
      case (raw)
         BASE_HEX_LO: b = BASE_HEX_LO;
         BASE_HEX_UP: b = BASE_HEX_UP;
         BASE_OCT:    b = BASE_OCT;
         BASE_BIN:    b = BASE_BIN;
         default:     b = BASE_DEC;
      endcase
      return b;
   endfunction

   function automatic logic [CHAR_W-1:0] digit_char(input logic [3:0] d, input logic upper);
      logic [CHAR_W-1:0] dw;
      dw = CHAR_W'(d);
      if (d < 4'd10) begin
         return CHAR_ZERO + dw;
      end else if (upper) begin
         return CHAR_A_UP + dw - CHAR_W'(10);
      end else begin
         return CHAR_A_LO + dw - CHAR_W'(10);
      end
   endfunction

endpackage

`default_nettype wire

// ===== src/itpt_if.sv =====
// Request and response channel interfaces of the padded text formatter.
// Depends on itpt_pkg for the field widths.
`default_nettype none

interface itpt_req_if;
   import itpt_pkg::*;
   logic                     valid;
   logic                     ready;
   logic [VALUE_W-1:0]       value;
   logic                     value_signed;
   logic                     format_mode;
   logic [BASE_W-1:0]        digit_base;
   logic [FIELD_WIDTH_W-1:0] field_width;
   logic                     left_align;
   logic                     plus_sign;
   logic                     zero_pad;

   modport source (output valid, value, value_signed, format_mode, digit_base, field_width,
                   left_align, plus_sign, zero_pad, input ready);
   modport sink   (input valid, value, value_signed, format_mode, digit_base, field_width,
                   left_align, plus_sign, zero_pad, output ready);
endinterface

interface itpt_rsp_if;
   import itpt_pkg::*;
   logic               valid;
   logic               ready;
   logic [CHAR_W-1:0]  char_first;
   logic [CHAR_W-1:0]  char_second;
   logic [CHAR_W-1:0]  char_third;
   logic [CHAR_W-1:0]  char_fourth;
   logic [COUNT_W-1:0] char_count;
   logic               last_group;

   modport source (output valid, char_first, char_second, char_third, char_fourth,
                   char_count, last_group, input ready);
   modport sink   (input valid, char_first, char_second, char_third, char_fourth,
                   char_count, last_group, output ready);
endinterface

`default_nettype wire

// ===== src/itpt_digit_sel.sv =====
// Digit selector: picks digit idx (least significant first) of the magnitude
// in the chosen base, or of the BCD word for decimal. Depends on itpt_pkg.
`default_nettype none

module itpt_digit_sel #(
   parameter int VALUE_BITS = itpt_pkg::VALUE_BITS_DEF
) (
   input  logic [VALUE_BITS-1:0]                          mag,
   input  logic [4*itpt_pkg::dec_digits(VALUE_BITS)-1:0]  bcd,
   input  itpt_pkg::base_type                             base,
   input  logic [$clog2(VALUE_BITS)-1:0]                  idx,
   output logic [3:0]                                     digit
);
   import itpt_pkg::*;

   localparam int IDX_W = $clog2(VALUE_BITS);
   localparam int BCD_W = 4 * dec_digits(VALUE_BITS);

   logic [BCD_W-1:0]      bcd_sh;
   logic [VALUE_BITS-1:0] hex_sh;
   logic [VALUE_BITS-1:0] oct_sh;
   logic [VALUE_BITS-1:0] bin_sh;
   logic [IDX_W+1:0]      oct_amt;

   assign oct_amt = (IDX_W+2)'({idx, 1'b0}) + (IDX_W+2)'(idx);
   assign bcd_sh  = bcd >> {idx, 2'b00};
   assign hex_sh  = mag >> {idx, 2'b00};
   assign oct_sh  = mag >> oct_amt;
   assign bin_sh  = mag >> idx;

   always_comb begin
      case (base)
         BASE_HEX_LO, BASE_HEX_UP: digit = hex_sh[3:0];
         BASE_OCT:                 digit = {1'b0, oct_sh[2:0]};
         BASE_BIN:                 digit = {3'b000, bin_sh[0]};
         BASE_DEC:                 digit = bcd_sh[3:0];
         default:                  digit = bcd_sh[3:0];
      endcase
   end

endmodule

`default_nettype wire

// ===== src/itpt_conv.sv =====
// Shared conversion unit: holds the magnitude and, for decimal, turns it into
// BCD one bit per cycle by shift and add-3. Depends on itpt_pkg.
`default_nettype none

module itpt_conv #(
   parameter int VALUE_BITS = itpt_pkg::VALUE_BITS_DEF
) (
   input  logic                                          clock,
   input  itpt_pkg::conv_cmd_type                        cmd,
   input  logic [VALUE_BITS-1:0]                         load_mag,
   output logic [VALUE_BITS-1:0]                         mag,
   output logic [4*itpt_pkg::dec_digits(VALUE_BITS)-1:0] bcd
);
   import itpt_pkg::*;

   localparam int DIGITS = dec_digits(VALUE_BITS);
   localparam int BCD_W  = 4 * DIGITS;

   logic [VALUE_BITS-1:0] mag_ff, mag_in;
   logic [BCD_W-1:0]      bcd_ff, bcd_in;
   logic [BCD_W-1:0]      adj;

   // Every BCD digit of five or more gets 3 added before the doubling shift.
   always_comb begin
      for (int i = 0; i < DIGITS; i++) begin
         if (bcd_ff[4*i +: 4] >= 4'd5) begin
            adj[4*i +: 4] = bcd_ff[4*i +: 4] + 4'd3;
         end else begin
            adj[4*i +: 4] = bcd_ff[4*i +: 4];
         end
      end
   end

   always_comb begin
      mag_in = mag_ff;
      bcd_in = bcd_ff;
      if (cmd.load) begin
         mag_in = load_mag;
         bcd_in = '0;
      end else if (cmd.step) begin
         mag_in = {mag_ff[VALUE_BITS-2:0], 1'b0};
         bcd_in = {adj[BCD_W-2:0], mag_ff[VALUE_BITS-1]};
      end
   end

   always_ff @(posedge clock) begin
      mag_ff <= mag_in;
      bcd_ff <= bcd_in;
   end

   assign mag = mag_ff;
   assign bcd = bcd_ff;

endmodule

`default_nettype wire

// ===== src/itpt_char_gen.sv =====
// Character lane: works out the character at one text position from the
// layout, the digits and the char-mode code point. Depends on itpt_pkg, itpt_digit_sel.
`default_nettype none

module itpt_char_gen #(
   parameter int VALUE_BITS = itpt_pkg::VALUE_BITS_DEF
) (
   input  itpt_pkg::lay_type                             lay,
   input  logic [itpt_pkg::POS_W-1:0]                    pos,
   input  logic [VALUE_BITS-1:0]                         mag,
   input  logic [4*itpt_pkg::dec_digits(VALUE_BITS)-1:0] bcd,
   input  logic [itpt_pkg::CHAR_W-1:0]                   code,
   output logic [itpt_pkg::CHAR_W-1:0]                   ch
);
   import itpt_pkg::*;

   localparam int IDX_W = $clog2(VALUE_BITS);

   logic [POS_W-1:0] rev_pos;
   logic [3:0]       digit;

   // Digits are stored least significant first, so count back from the end.
   assign rev_pos = lay.dend - pos - POS_W'(1);

   itpt_digit_sel #(
      .VALUE_BITS (VALUE_BITS)
   ) u_sel (
      .mag   (mag),
      .bcd   (bcd),
      .base  (lay.base),
      .idx   (rev_pos[IDX_W-1:0]),
      .digit (digit)
   );

   always_comb begin
      if (pos >= lay.total) begin
         ch = '0;
      end else if (pos < lay.lead_sp) begin
         ch = CHAR_SPACE;
      end else if (lay.has_sign && (pos == lay.lead_sp)) begin
         ch = lay.sign_neg ? CHAR_MINUS : CHAR_PLUS;
      end else if (pos < lay.dstart) begin
         ch = CHAR_ZERO;
      end else if (pos < lay.dend) begin
         ch = lay.char_mode ? code : digit_char(digit, lay.base == BASE_HEX_UP);
      end else begin
         ch = CHAR_SPACE;
      end
   end

endmodule

`default_nettype wire

// ===== src/integer_to_padded_text.sv =====
// Channel | Dir | Contents
// req_bus | in  | value, value_signed, format_mode, digit_base, field_width, flags
// rsp_bus | out | char_first..char_fourth, char_count, last_group
//
// Decimal loads the magnitude, runs the shift/add-3 unit, scans for the leading
// digit, lays out the text and emits groups of four chars. Other bases skip the
// conversion: load, scan, layout, groups. Char mode: load, layout, groups. Reset
// is synchronous and clears the sequencer and the response valid; a stalled
// response holds emission, but a request is taken while the final group waits.
//
// Top level of the padded text formatter: sequencer, item registers, four
// character lanes and the response register. Depends on itpt_pkg, itpt_if,
// itpt_conv, itpt_char_gen, itpt_digit_sel and assert_macros.svh.
`default_nettype none
`include "assert_macros.svh"

module integer_to_padded_text #(
   parameter int WIDTH_CAP  = itpt_pkg::WIDTH_CAP_DEF,
   parameter int VALUE_BITS = itpt_pkg::VALUE_BITS_DEF
) (
   input  logic       clock,
   input  logic       reset,
   itpt_req_if.sink   req_bus,
   itpt_rsp_if.source rsp_bus
);
   import itpt_pkg::*;

   localparam int DEC_DIGITS = dec_digits(VALUE_BITS);
   localparam int BCD_W      = 4 * DEC_DIGITS;
   localparam int HEX_DIGITS = (VALUE_BITS + 3) / 4;
   localparam int OCT_DIGITS = (VALUE_BITS + 2) / 3;
   localparam int IDX_W      = $clog2(VALUE_BITS);
   localparam int NDIG_W     = $clog2(VALUE_BITS + 1);
   localparam int CNT_W      = $clog2(VALUE_BITS);
   localparam logic [FIELD_WIDTH_W:0] MAXW = (FIELD_WIDTH_W+1)'(WIDTH_CAP);

   state_type state_ff, state_in;

   logic                     req_ready;
   logic                     accept;
   conv_cmd_type             conv_cmd;
   logic                     scan_en;
   logic                     layout_en;
   logic                     emit_go;
   logic                     emit_last;
   logic                     conv_last;
   logic                     scan_done;

   logic [VALUE_BITS-1:0]    in_value;
   logic                     in_neg;
   logic [VALUE_BITS-1:0]    in_mag;
   base_type                 in_base;
   logic [FIELD_WIDTH_W-1:0] in_width;
   logic [IDX_W-1:0]         in_start_idx;

   lay_type                  lay_ff, lay_in;
   logic                     left_ff, left_in;
   logic                     zpad_ff, zpad_in;
   logic [FIELD_WIDTH_W-1:0] width_ff, width_in;
   logic [CHAR_W-1:0]        code_ff, code_in;
   logic [IDX_W-1:0]         idx_ff, idx_in;
   logic [CNT_W-1:0]         cnt_ff, cnt_in;
   logic [NDIG_W-1:0]        ndig_ff, ndig_in;
   logic [POS_W-1:0]         pos_ff, pos_in;

   logic [POS_W-1:0]         len;
   logic [POS_W-1:0]         fld;
   logic [POS_W-1:0]         pad;
   logic [POS_W-1:0]         rem;

   logic [VALUE_BITS-1:0]    mag;
   logic [BCD_W-1:0]         bcd;
   logic [3:0]               scan_digit;
   logic [CHAR_W-1:0]        lane_ch [GROUP_CHARS];

   logic                     rsp_valid_ff, rsp_valid_in;
   logic [CHAR_W-1:0]        first_ff, second_ff, third_ff, fourth_ff;
   logic [COUNT_W-1:0]       count_ff, count_in;
   logic                     last_ff;

   // Request decode.
   assign in_value = req_bus.value[VALUE_BITS-1:0];
   assign in_neg   = req_bus.value_signed && in_value[VALUE_BITS-1];
   assign in_mag   = in_neg ? (~in_value + VALUE_BITS'(1)) : in_value;
   assign in_base  = decode_base(req_bus.digit_base);
   assign in_width = ({1'b0, req_bus.field_width} > MAXW) ? MAXW[FIELD_WIDTH_W-1:0]
                                                          : req_bus.field_width;

   always_comb begin
      case (in_base)
         BASE_HEX_LO, BASE_HEX_UP: in_start_idx = IDX_W'(HEX_DIGITS - 1);
         BASE_OCT:                 in_start_idx = IDX_W'(OCT_DIGITS - 1);
         BASE_BIN:                 in_start_idx = IDX_W'(VALUE_BITS - 1);
         BASE_DEC:                 in_start_idx = IDX_W'(DEC_DIGITS - 1);
         default:                  in_start_idx = IDX_W'(DEC_DIGITS - 1);
      endcase
   end

   assign conv_last = cnt_ff == CNT_W'(VALUE_BITS - 1);
   assign scan_done = (scan_digit != 4'd0) || (idx_ff == '0);
   assign rem       = lay_ff.total - pos_ff;
   assign emit_last = rem <= POS_W'(GROUP_CHARS);

   // Next state.
   always_comb begin
      state_in = state_ff;
      case (state_ff)
         ST_IDLE: begin
            if (req_bus.valid) begin
               if (req_bus.format_mode) begin
                  state_in = ST_LAYOUT;
               end else if (in_base == BASE_DEC) begin
                  state_in = ST_CONV;
               end else begin
                  state_in = ST_SCAN;
               end
            end
         end
         ST_CONV: begin
            if (conv_last) state_in = ST_SCAN;
         end
         ST_SCAN: begin
            if (scan_done) state_in = ST_LAYOUT;
         end
         ST_LAYOUT: state_in = ST_EMIT;
         ST_EMIT: begin
            if (emit_go && emit_last) state_in = ST_IDLE;
         end
         default: state_in = ST_IDLE;
      endcase
   end

   // Sequencer outputs.
   always_comb begin
      req_ready = 1'b0;
      conv_cmd  = '0;
      scan_en   = 1'b0;
      layout_en = 1'b0;
      emit_go   = 1'b0;
      case (state_ff)
         ST_IDLE: begin
            req_ready     = 1'b1;
            conv_cmd.load = req_bus.valid;
         end
         ST_CONV:   conv_cmd.step = 1'b1;
         ST_SCAN:   scan_en = 1'b1;
         ST_LAYOUT: layout_en = 1'b1;
         ST_EMIT:   emit_go = !rsp_valid_ff || rsp_bus.ready;
         default:   ;
      endcase
   end

   assign req_bus.ready = req_ready;
   assign accept        = req_bus.valid && req_ready;

   // Layout of the text: [spaces][sign][zeros][digits][spaces].
   assign len = POS_W'(ndig_ff) + POS_W'(lay_ff.has_sign);
   assign fld = POS_W'(width_ff);
   assign pad = (fld > len) ? fld - len : '0;

   always_comb begin
      lay_in    = lay_ff;
      left_in   = left_ff;
      zpad_in   = zpad_ff;
      width_in  = width_ff;
      code_in   = code_ff;
      idx_in    = idx_ff;
      cnt_in    = cnt_ff;
      ndig_in   = ndig_ff;
      pos_in    = pos_ff;
      if (accept) begin
         lay_in.base      = in_base;
         lay_in.char_mode = req_bus.format_mode;
         lay_in.has_sign  = !req_bus.format_mode && (in_neg || req_bus.plus_sign);
         lay_in.sign_neg  = in_neg;
         left_in          = req_bus.left_align;
         zpad_in          = req_bus.zero_pad;
         width_in         = in_width;
         code_in          = req_bus.value[CHAR_W-1:0];
         idx_in           = in_start_idx;
         cnt_in           = '0;
         ndig_in          = NDIG_W'(1);
         pos_in           = '0;
      end
      if (conv_cmd.step) begin
         cnt_in = cnt_ff + CNT_W'(1);
      end
      if (scan_en) begin
         if (scan_done) begin
            ndig_in = NDIG_W'(idx_ff) + NDIG_W'(1);
         end else begin
            idx_in = idx_ff - IDX_W'(1);
         end
      end
      if (layout_en) begin
         lay_in.total   = (fld > len) ? fld : len;
         lay_in.lead_sp = (!left_ff && !zpad_ff) ? pad : '0;
         lay_in.dstart  = (left_ff ? '0 : pad) + POS_W'(lay_ff.has_sign);
         lay_in.dend    = (left_ff ? '0 : pad) + len;
      end
      if (emit_go) begin
         pos_in = pos_ff + POS_W'(GROUP_CHARS);
      end
   end

   itpt_conv #(
      .VALUE_BITS (VALUE_BITS)
   ) u_conv (
      .clock    (clock),
      .cmd      (conv_cmd),
      .load_mag (in_mag),
      .mag      (mag),
      .bcd      (bcd)
   );

   itpt_digit_sel #(
      .VALUE_BITS (VALUE_BITS)
   ) u_scan_sel (
      .mag   (mag),
      .bcd   (bcd),
      .base  (lay_ff.base),
      .idx   (idx_ff),
      .digit (scan_digit)
   );

   for (genvar j = 0; j < GROUP_CHARS; j++) begin : g_lane
      itpt_char_gen #(
         .VALUE_BITS (VALUE_BITS)
      ) u_lane (
         .lay  (lay_ff),
         .pos  (pos_ff + POS_W'(j)),
         .mag  (mag),
         .bcd  (bcd),
         .code (code_ff),
         .ch   (lane_ch[j])
      );
   end

   // Response register: a new request can be taken while the final group waits here.
   assign count_in = emit_last ? rem[COUNT_W-1:0] : COUNT_W'(GROUP_CHARS);

   always_comb begin
      rsp_valid_in = rsp_valid_ff;
      if (emit_go) begin
         rsp_valid_in = 1'b1;
      end else if (rsp_bus.ready) begin
         rsp_valid_in = 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= ST_IDLE;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      lay_ff   <= lay_in;
      left_ff  <= left_in;
      zpad_ff  <= zpad_in;
      width_ff <= width_in;
      code_ff  <= code_in;
      idx_ff   <= idx_in;
      cnt_ff   <= cnt_in;
      ndig_ff  <= ndig_in;
      pos_ff   <= pos_in;
      if (emit_go) begin
         first_ff  <= lane_ch[0];
         second_ff <= lane_ch[1];
         third_ff  <= lane_ch[2];
         fourth_ff <= lane_ch[3];
         count_ff  <= count_in;
         last_ff   <= emit_last;
      end
   end

   assign rsp_bus.valid       = rsp_valid_ff;
   assign rsp_bus.char_first  = first_ff;
   assign rsp_bus.char_second = second_ff;
   assign rsp_bus.char_third  = third_ff;
   assign rsp_bus.char_fourth = fourth_ff;
   assign rsp_bus.char_count  = count_ff;
   assign rsp_bus.last_group  = last_ff;

   `ASSERT_IMPL(a_count_range, clock, reset, rsp_bus.valid, (rsp_bus.char_count != '0) && (rsp_bus.char_count <= COUNT_W'(GROUP_CHARS)), "response group count out of range")
   `ASSERT_IMPL(a_short_group_clear, clock, reset, rsp_bus.valid && (rsp_bus.char_count != COUNT_W'(GROUP_CHARS)), rsp_bus.char_fourth == '0, "unused character slot not cleared")
   `ASSERT_HOLDS(a_pos_in_text, clock, reset, (state_ff != ST_EMIT) || (pos_ff < lay_ff.total), "emission position beyond the text")
   `ASSERT_NEXT(a_last_to_idle, clock, reset, emit_go && emit_last, req_bus.ready && rsp_bus.valid && rsp_bus.last_group, "final group did not end the request")

endmodule

`default_nettype wire
